@@ rtl/bb3_pkg.sv @@
// Package of the 3x3 box blur: frame limits, field widths, register indexes,
// the queue entry type and the reciprocal table of the rounding divider.
// Used by the queue, front, back and top level of the block and by its testbench.
package bb3_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int OROW_W = $clog2(MAX_HEIGHT);
  localparam int ROW_W = OROW_W + 1;
  localparam int FW_W = 11;
  localparam int FH_W = 13;
  localparam int CFG_W = 13;
  localparam int PIX_W = 24;
  localparam int CH_W = 8;
  localparam int SUM_W = 12;
  localparam int CNT_W = 4;
  localparam int NUM_W = 13;
  localparam int RECIP_K = 19;
  localparam int RECIP_W = 19;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic REG_FRAME_WIDTH = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [COL_W-1:0] addr;
    logic             emit;
    logic             use_left;
    logic             use_right;
    logic             use_top;
    logic             use_bottom;
    logic             frame_end;
  } adv_t;

  // Rounded-up 2^19 / (2n) for every neighbor count that can occur.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    unique case (n)
      CNT_W'(1): r = RECIP_W'(262144);
      CNT_W'(2): r = RECIP_W'(131072);
      CNT_W'(3): r = RECIP_W'(87382);
      CNT_W'(4): r = RECIP_W'(65536);
      CNT_W'(6): r = RECIP_W'(43691);
      CNT_W'(9): r = RECIP_W'(29128);
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/bb3_stream_if.sv @@
// Stream interfaces of the 3x3 box blur: pixel beats in and blurred beats out.
// Depends on nothing.
interface bb3_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, operation, red_in, green_in, blue_in, input ready);
  modport sink (input valid, operation, red_in, green_in, blue_in, output ready);
endinterface

interface bb3_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_end;
  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

@@ rtl/bb3_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/bb3_queue.sv @@
// Short queue of pipeline steps between the front and back parts of the blur.
// Depends on bb3_pkg.
module bb3_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bb3_pkg::adv_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output bb3_pkg::adv_t pop_data
);
  import bb3_pkg::*;

  adv_t           slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full = (count == (QAW+1)'(QDEPTH));
  assign pop_valid = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + (QAW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QAW+1)'(1);
      end
    end
  end

endmodule

@@ rtl/bb3_front.sv @@
// Front part of the blur: takes input beats and configuration, tracks input and
// output positions, and queues pipeline steps with their edge masks. Depends on bb3_pkg.
module bb3_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]  cfg_data,
  bb3_in_if.sink                     pixel_in,
  input  logic                       full,
  output logic                       push,
  output bb3_pkg::adv_t              entry
);
  import bb3_pkg::*;

  logic [FW_W-1:0]   fw;
  logic [FH_W-1:0]   fh;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  ocol;
  logic [OROW_W-1:0] orow;
  logic              pend;

  logic accept, in_frame, push_px, drain, is_emit;
  logic last_col, olast_col, olast_row;
  logic [FW_W-1:0] wval;
  logic [FH_W-1:0] hval;

  assign pixel_in.ready = !pend && !full;
  assign accept = pixel_in.valid && pixel_in.ready;
  assign in_frame = row < ROW_W'(fh);
  assign push_px = accept && (pixel_in.operation == OP_PUSH) && in_frame;
  assign drain = accept && (pixel_in.operation == OP_DRAIN) && !in_frame;
  assign push = push_px || drain || (pend && !full);

  assign is_emit = (row >= ROW_W'(2)) || ((row == ROW_W'(1)) && (col != '0));
  assign last_col = ({1'b0, col} == fw - FW_W'(1));
  assign olast_col = ({1'b0, ocol} == fw - FW_W'(1));
  assign olast_row = ({1'b0, orow} == fh - FH_W'(1));

  always_comb begin
    entry.px = push_px ? {pixel_in.red_in, pixel_in.green_in, pixel_in.blue_in} : '0;
    entry.addr = col;
    entry.emit = is_emit;
    entry.use_left = (ocol != '0);
    entry.use_right = !olast_col;
    entry.use_top = (orow != '0);
    entry.use_bottom = !olast_row;
    entry.frame_end = is_emit && olast_col && olast_row;
  end

  always_comb begin
    wval = cfg_data[FW_W-1:0];
    if (wval == '0) begin
      wval = FW_W'(1);
    end else if (wval > FW_W'(MAX_WIDTH)) begin
      wval = FW_W'(MAX_WIDTH);
    end
    hval = cfg_data[FH_W-1:0];
    if (hval == '0) begin
      hval = FH_W'(1);
    end else if (hval > FH_W'(MAX_HEIGHT)) begin
      hval = FH_W'(MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fw <= FW_RESET;
      fh <= FH_RESET;
      col <= '0;
      row <= '0;
      ocol <= '0;
      orow <= '0;
      pend <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        fw <= wval;
      end else begin
        fh <= hval;
      end
      col <= '0;
      row <= '0;
      ocol <= '0;
      orow <= '0;
      pend <= 1'b0;
    end else begin
      if (drain && !is_emit) begin
        pend <= 1'b1;
      end else if (pend && !full) begin
        pend <= 1'b0;
      end
      if (push) begin
        if (entry.frame_end) begin
          col <= '0;
          row <= '0;
          ocol <= '0;
          orow <= '0;
        end else begin
          if (last_col) begin
            col <= '0;
            row <= row + ROW_W'(1);
          end else begin
            col <= col + COL_W'(1);
          end
          if (is_emit) begin
            if (olast_col) begin
              ocol <= '0;
              orow <= orow + OROW_W'(1);
            end else begin
              ocol <= ocol + COL_W'(1);
            end
          end
        end
      end
    end
  end

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    push && entry.frame_end |=> (ocol == '0) && (orow == '0) && (row == '0))
    else $error("output position not restarted after the last pixel of a frame");

endmodule

@@ rtl/bb3_back.sv @@
// Back part of the blur: line-store read-modify-write, 3x3 window, masked sums
// and the rounding divide into the output register. Depends on bb3_pkg and bb3_ram.
module bb3_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  bb3_pkg::adv_t q_entry,
  output logic          q_pop,
  bb3_out_if.source     pixel_out
);
  import bb3_pkg::*;

  logic             s1_valid;
  adv_t             s1_e;
  logic [PIX_W-1:0] top_rd;
  logic [PIX_W-1:0] mid_rd;
  logic             s1_adv;

  logic [2:0][PIX_W-1:0] win1;
  logic [2:0][PIX_W-1:0] win2;

  logic             s2_valid;
  logic [SUM_W-1:0] s2_sum [3];
  logic [CNT_W-1:0] s2_n;
  logic             s2_fe;
  logic             s2_ready;
  logic             s2_adv;

  logic [SUM_W-1:0] sum [3];
  logic [CNT_W-1:0] n;
  logic [CH_W-1:0]  quo [3];

  assign q_pop = q_valid && !s1_valid;

  bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .we(s1_adv), .waddr(s1_e.addr), .wdata(mid_rd),
    .re(q_pop), .raddr(q_entry.addr), .rdata(top_rd)
  );

  bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk(clk), .we(s1_adv), .waddr(s1_e.addr), .wdata(s1_e.px),
    .re(q_pop), .raddr(q_entry.addr), .rdata(mid_rd)
  );

  assign s2_adv = s2_valid && (!pixel_out.valid || pixel_out.ready);
  assign s2_ready = !s2_valid || s2_adv;
  assign s1_adv = s1_valid && (!s1_e.emit || s2_ready);

  always_comb begin
    logic [PIX_W-1:0] p;
    logic             use_px;
    for (int k = 0; k < 3; k++) begin
      sum[k] = '0;
    end
    n = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (c == 0) begin
          p = win1[r];
        end else if (c == 1) begin
          p = win2[r];
        end else begin
          p = (r == 0) ? top_rd : ((r == 1) ? mid_rd : s1_e.px);
        end
        use_px = (c != 0 || s1_e.use_left) && (c != 2 || s1_e.use_right) &&
                 (r != 0 || s1_e.use_top) && (r != 2 || s1_e.use_bottom);
        if (use_px) begin
          sum[0] = sum[0] + SUM_W'(p[23:16]);
          sum[1] = sum[1] + SUM_W'(p[15:8]);
          sum[2] = sum[2] + SUM_W'(p[7:0]);
          n = n + CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    logic [NUM_W-1:0]         num;
    logic [NUM_W+RECIP_W-1:0] prod;
    for (int k = 0; k < 3; k++) begin
      num = {s2_sum[k], 1'b0} + NUM_W'(s2_n);
      prod = (NUM_W+RECIP_W)'(num) * (NUM_W+RECIP_W)'(recip(s2_n));
      quo[k] = prod[RECIP_K +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_e <= q_entry;
    end
    if (s1_adv) begin
      win1 <= win2;
      win2 <= {s1_e.px, mid_rd, top_rd};
    end
    if (s1_adv && s1_e.emit) begin
      s2_sum <= sum;
      s2_n <= n;
      s2_fe <= s1_e.frame_end;
    end
    if (s2_adv) begin
      pixel_out.red_out <= quo[0];
      pixel_out.green_out <= quo[1];
      pixel_out.blue_out <= quo[2];
      pixel_out.frame_end <= s2_fe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      pixel_out.valid <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv && s1_e.emit) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv) begin
        pixel_out.valid <= 1'b1;
      end else if (pixel_out.ready) begin
        pixel_out.valid <= 1'b0;
      end
    end
  end

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_e))
    else $error("line-store step lost while stalled");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_adv |=> s2_valid && $stable(s2_n) && $stable(s2_fe))
    else $error("sum stage changed while stalled");

  a_count_legal: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (s2_n == CNT_W'(1)) || (s2_n == CNT_W'(2)) || (s2_n == CNT_W'(3)) ||
                 (s2_n == CNT_W'(4)) || (s2_n == CNT_W'(6)) || (s2_n == CNT_W'(9)))
    else $error("neighbor count outside the divider table");

endmodule

@@ rtl/box_blur_3x3_rgb.sv @@
// Top level of the 3x3 RGB box blur: front, step queue and back part.
// A pixel step is a line-store read-modify-write, and no step leaves the queue while one is in
// that stage; a result passes the queue, line-store stage, sum stage and output register.
// The first drain of a single-row frame makes two steps. Output lags input by a row plus a pixel.
// Synchronous reset sets the frame to 640 x 480 and clears all positions;
// the line stores are not cleared.
module box_blur_3x3_rgb (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0] cfg_data,
  bb3_in_if.sink                    pixel_in,
  bb3_out_if.source                 pixel_out
);
  import bb3_pkg::*;

  logic push, full, pop, pop_valid;
  adv_t push_data;
  adv_t pop_data;

  bb3_front u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pixel_in(pixel_in), .full(full), .push(push), .entry(push_data)
  );

  bb3_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(full),
    .pop(pop), .pop_valid(pop_valid), .pop_data(pop_data)
  );

  bb3_back u_back (
    .clk(clk), .rst(rst), .q_valid(pop_valid), .q_entry(pop_data), .q_pop(pop),
    .pixel_out(pixel_out)
  );

endmodule

@@ tb/box_blur_3x3_rgb_checker.sv @@
`timescale 1ns / 1ps
// Checker of the 3x3 RGB box blur: predicts every blurred beat from the accepted
// input beats and register writes, and compares it with the output channel.
// Depends on bb3_pkg and the stream interfaces of the block.
module box_blur_3x3_rgb_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0] cfg_data,
  bb3_in_if                         pin,
  bb3_out_if                        pout,
  output int                        fail_count,
  output int                        pending_pixels,
  output int                        blurred_seen
);
  import bb3_pkg::*;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } blur_px_t;

  blur_px_t            blurred_q[$];
  logic [PIX_W-1:0]    upper_store[MAX_WIDTH];
  logic [PIX_W-1:0]    middle_store[MAX_WIDTH];
  logic [PIX_W-1:0]    win[3][3];
  int unsigned         width_px, height_px, in_col, in_row, out_pos;

  function automatic void restart_frame();
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) win[c][r] = '0;
    end
    in_col = 0;
    in_row = 0;
    out_pos = 0;
  endfunction

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit blur_step(input logic [PIX_W-1:0] px, output blur_px_t res);
    int unsigned      x, q, cr, cc, n;
    int unsigned      sum[3];
    logic [PIX_W-1:0] top, mid, p;
    x = in_col;
    q = in_row * width_px + in_col;
    top = '0;
    mid = '0;
    res = '{default: '0};
    if (x < MAX_WIDTH) begin
      top = upper_store[x];
      mid = middle_store[x];
      upper_store[x] = mid;
      middle_store[x] = px;
    end
    for (int r = 0; r < 3; r++) begin
      win[0][r] = win[1][r];
      win[1][r] = win[2][r];
    end
    win[2][0] = top;
    win[2][1] = mid;
    win[2][2] = px;
    in_col++;
    if (in_col >= width_px) begin
      in_col = 0;
      in_row++;
    end
    if (q < width_px + 1) return 0;
    cr = out_pos / width_px;
    cc = out_pos % width_px;
    sum = '{0, 0, 0};
    n = 0;
    for (int c = 0; c < 3; c++) begin
      if (!(c == 0 && cc == 0) && !(c == 2 && cc + 1 >= width_px)) begin
        for (int r = 0; r < 3; r++) begin
          if (!(r == 0 && cr == 0) && !(r == 2 && cr + 1 >= height_px)) begin
            p = win[c][r];
            sum[0] += p[23:16];
            sum[1] += p[15:8];
            sum[2] += p[7:0];
            n++;
          end
        end
      end
    end
    res.red = 8'((2 * sum[0] + n) / (2 * n));
    res.green = 8'((2 * sum[1] + n) / (2 * n));
    res.blue = 8'((2 * sum[2] + n) / (2 * n));
    out_pos++;
    if (out_pos >= width_px * height_px) begin
      res.frame_end = 1'b1;
      restart_frame();
    end
    return 1;
  endfunction

  always @(posedge clk) begin
    blur_px_t res, exp_px;
    bit       made;
    if (rst) begin
      width_px = 640;
      height_px = 480;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_store[i] = '0;
        middle_store[i] = '0;
      end
      restart_frame();
      blurred_q.delete();
      fail_count <= 0;
      blurred_seen <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          width_px = clamp_dim(cfg_data[FW_W-1:0], MAX_WIDTH);
        end else begin
          height_px = clamp_dim(cfg_data[FH_W-1:0], MAX_HEIGHT);
        end
        restart_frame();
      end
      if (pin.valid && pin.ready) begin
        made = 0;
        if (pin.operation == OP_PUSH) begin
          if (in_row < height_px) begin
            made = blur_step({pin.red_in, pin.green_in, pin.blue_in}, res);
          end
        end else if (in_row >= height_px) begin
          made = blur_step('0, res);
          if (!made) made = blur_step('0, res);
        end
        if (made) blurred_q.push_back(res);
      end
      if (pout.valid && pout.ready) begin
        blurred_seen <= blurred_seen + 1;
        if (blurred_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("Unexpected output beat: %h %h %h end=%b",
                                        pout.red_out, pout.green_out, pout.blue_out,
                                        pout.frame_end);
        end else begin
          exp_px = blurred_q.pop_front();
          if (exp_px.red !== pout.red_out || exp_px.green !== pout.green_out ||
              exp_px.blue !== pout.blue_out || exp_px.frame_end !== pout.frame_end) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) begin
              $display("Mismatch: expected %h %h %h end=%b, got %h %h %h end=%b",
                       exp_px.red, exp_px.green, exp_px.blue, exp_px.frame_end,
                       pout.red_out, pout.green_out, pout.blue_out, pout.frame_end);
            end
          end
        end
      end
    end
    pending_pixels <= blurred_q.size();
  end
endmodule

@@ tb/box_blur_3x3_rgb_tb.sv @@
`timescale 1ns / 1ps
// Top of the box blur testbench: clock, reset, frame stimulus with random stalls
// and the verdict. Depends on bb3_pkg, the stream interfaces, the block and its checker.
module box_blur_3x3_rgb_tb;
  import bb3_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic             cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  int               fail_count, pending_pixels, blurred_seen;
  int               cycles = 0;
  int               beats_sent = 0;
  int               frames_run = 0;
  bit               steady;

  bb3_in_if  pin();
  bb3_out_if pout();

  box_blur_3x3_rgb u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pixel_in(pin), .pixel_out(pout)
  );

  box_blur_3x3_rgb_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pin(pin), .pout(pout), .fail_count(fail_count), .pending_pixels(pending_pixels),
    .blurred_seen(blurred_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  assign steady = (cycles >= 1000 && cycles < 1700);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    pin.valid = 1'b0;
    pin.operation = OP_PUSH;
    pin.red_in = '0;
    pin.green_in = '0;
    pin.blue_in = '0;
    pout.ready = 1'b0;
  end

  always @(negedge clk) pout.ready = steady || ($urandom_range(99) >= 24);

  task automatic send_beat(input logic op, input logic [7:0] r, g, b);
    while (!steady && $urandom_range(99) < 24) begin
      pin.valid = 1'b0;
      @(negedge clk);
    end
    pin.valid = 1'b1;
    pin.operation = op;
    pin.red_in = r;
    pin.green_in = g;
    pin.blue_in = b;
    @(posedge clk);
    while (!pin.ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic push_random(input int style);
    logic [7:0] r, g, b;
    r = 8'($urandom_range(255));
    g = 8'($urandom_range(255));
    b = 8'($urandom_range(255));
    if (style == 0) {r, g, b} = '0;
    if (style == 1) {r, g, b} = '1;
    send_beat(OP_PUSH, r, g, b);
  endtask

  task automatic settle();
    pin.valid = 1'b0;
    while (pending_pixels != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input int unsigned val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_W'(val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_frame(input int unsigned wr, hr, input bit noisy, input bit abort);
    int unsigned w, h, total, stop_at;
    w = (wr[10:0] == 0) ? 1 : (wr[10:0] > MAX_WIDTH ? MAX_WIDTH : wr[10:0]);
    h = (hr[12:0] == 0) ? 1 : (hr[12:0] > MAX_HEIGHT ? MAX_HEIGHT : hr[12:0]);
    total = w * h;
    stop_at = abort ? $urandom_range(1, (total < 40) ? total : 40) : total;
    settle();
    write_reg(REG_FRAME_WIDTH, wr);
    write_reg(REG_FRAME_HEIGHT, hr);
    frames_run++;
    for (int i = 0; i < stop_at; i++) begin
      if (noisy && $urandom_range(19) == 0) begin
        send_beat(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      push_random($urandom_range(7));
    end
    if (abort) return;
    if (noisy) push_random(2);
    for (int i = 0; i < ((total < w + 1) ? total : w + 1); i++) begin
      send_beat(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
    end
    if (noisy && $urandom_range(3) == 0) send_beat(OP_DRAIN, 8'hff, 8'h00, 8'hff);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_frame(0, 0, 1'b1, 1'b0);
    run_frame(3, 3, 1'b1, 1'b0);
    run_frame(2, 2, 1'b0, 1'b0);
    run_frame(1, 3, 1'b1, 1'b0);
    run_frame(4, 1, 1'b1, 1'b0);
    run_frame(5, 8191, 1'b0, 1'b1);
    run_frame(2047, 1, 1'b0, 1'b1);
    run_frame(1024, 4096, 1'b0, 1'b1);

    while (beats_sent < 1050) begin
      if ($urandom_range(9) == 0) begin
        run_frame($urandom_range(1, 40), $urandom_range(1, 6), 1'b1, $urandom_range(2) == 0);
      end else begin
        run_frame($urandom_range(1, 12), $urandom_range(1, 8), 1'b1, 1'b0);
      end
    end

    settle();
    repeat (20) @(negedge clk);
    $display("Sent %0d input beats over %0d frame setups; checked %0d blurred beats.",
             beats_sent, frames_run, blurred_seen);
    if (fail_count == 0 && pending_pixels == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d beats outstanding.", fail_count, pending_pixels);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ box_blur_3x3_rgb.f @@
rtl/bb3_pkg.sv
rtl/bb3_stream_if.sv
rtl/bb3_ram.sv
rtl/bb3_queue.sv
rtl/bb3_front.sv
rtl/bb3_back.sv
rtl/box_blur_3x3_rgb.sv
tb/box_blur_3x3_rgb_checker.sv
tb/box_blur_3x3_rgb_tb.sv
